>>> src/spp_pkg.sv
// ----------------------------------------------------------------------------
// spp_pkg
// Shared widths and result codes for the segment pair proximity test.
// ----------------------------------------------------------------------------
package spp_pkg;

  // Coordinate width and derived datapath widths.
  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned BUF_BITS   = 15;
  localparam int unsigned DW  = COORD_BITS + 1;       // coordinate difference
  localparam int unsigned LW  = (DW > BUF_BITS + 2) ? DW : BUF_BITS + 2;
  localparam int unsigned PW  = 2 * DW;               // product of differences
  localparam int unsigned SW  = PW + 1;               // sum of two products
  localparam int unsigned DDW = 2 * BUF_BITS + 1;     // squared radius, signed

  // Which rule settled the result.
  typedef enum logic [2:0] {
    HOW_AXIS  = 3'd0,
    HOW_POINT = 3'd1,
    HOW_DEGEN = 3'd2,
    HOW_CROSS = 3'd3,
    HOW_NONE  = 3'd4
  } how_e;

endpackage

>>> src/spp_in_if.sv
// ----------------------------------------------------------------------------
// spp_in_if
// Input channel: one segment pair per transfer.
// ----------------------------------------------------------------------------
interface spp_in_if;
  import spp_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] first_start_x;
  logic signed [COORD_BITS-1:0] first_start_y;
  logic signed [COORD_BITS-1:0] first_end_x;
  logic signed [COORD_BITS-1:0] first_end_y;
  logic signed [COORD_BITS-1:0] second_start_x;
  logic signed [COORD_BITS-1:0] second_start_y;
  logic signed [COORD_BITS-1:0] second_end_x;
  logic signed [COORD_BITS-1:0] second_end_y;

  modport source (output valid, first_start_x, first_start_y, first_end_x, first_end_y,
                  second_start_x, second_start_y, second_end_x, second_end_y,
                  input ready);
  modport sink (input valid, first_start_x, first_start_y, first_end_x, first_end_y,
                second_start_x, second_start_y, second_end_x, second_end_y,
                output ready);
endinterface

>>> src/spp_out_if.sv
// ----------------------------------------------------------------------------
// spp_out_if
// Result channel: proximity flag and the rule that decided it.
// ----------------------------------------------------------------------------
interface spp_out_if;
  logic       valid;
  logic       ready;
  logic       close;
  logic [2:0] decided_by;

  modport source (output valid, close, decided_by, input ready);
  modport sink (input valid, close, decided_by, output ready);
endinterface

>>> src/segment_pair_proximity_test.sv
// Each input transfer is registered through stages 1 to 5; the stage 5 result
// register drives res_o.
// Throughput: one segment pair per cycle unless stalled; the five stages advance together.
// A stalled result holds every stage; nothing is lost or repeated.
// Reset (rst_ni low, asynchronous) empties the pipeline and clears the
// buffer distance to zero.
// ----------------------------------------------------------------------------
// segment_pair_proximity_test
// Flags whether two 2-D segments come within the buffer distance, using an
// axis filter, four point-to-segment tests, a zero-length check and a
// proper-crossing test, in a five stage pipeline.
// ----------------------------------------------------------------------------
module segment_pair_proximity_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          buffer_distance_we_i,
  input  logic [spp_pkg::BUF_BITS-1:0]  buffer_distance_i,
  spp_in_if.sink                        seg_i,
  spp_out_if.source                     res_o
);
  import spp_pkg::*;

  logic                en;
  logic [BUF_BITS-1:0] buf_q;
  logic                v1_q, v2_q, v3_q, v4_q, v5_q;

  // Whole pipeline moves unless the result register is stalled.
  assign en          = !v5_q || res_o.ready;
  assign seg_i.ready = en;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
    end else if (buffer_distance_we_i) begin
      buf_q <= buffer_distance_i;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else if (en) begin
      v1_q <= seg_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  // Points: 0 first start, 1 first end, 2 second start, 3 second end.
  logic signed [COORD_BITS-1:0] ptx [4];
  logic signed [COORD_BITS-1:0] pty [4];
  assign ptx[0] = seg_i.first_start_x;
  assign pty[0] = seg_i.first_start_y;
  assign ptx[1] = seg_i.first_end_x;
  assign pty[1] = seg_i.first_end_y;
  assign ptx[2] = seg_i.second_start_x;
  assign pty[2] = seg_i.second_start_y;
  assign ptx[3] = seg_i.second_end_x;
  assign pty[3] = seg_i.second_end_y;

  logic signed [LW-1:0] lim, nlim;
  assign lim  = LW'({1'b0, buf_q, 1'b0});
  assign nlim = -lim;

  // ---------------- Stage 1: differences and separation filters ----------
  logic signed [DW-1:0] wx1_q [4], wy1_q [4], ux1_q [4], uy1_q [4];
  logic signed [DW-1:0] vx1_q [4], vy1_q [4];
  logic                 rej1_q [4];
  logic signed [DW-1:0] obx1_q [4], oby1_q [4], ocx1_q [4], ocy1_q [4];
  logic                 axis1_q, degen1_q;
  logic [BUF_BITS-1:0]  b1_q;

  logic signed [LW-1:0] ax_d [4], ay_d [4];
  logic                 axis_d;

  // Pair filter differences: s1-s2, s1-e2, e1-e2, e1-s2 on each axis.
  always_comb begin
    ax_d[0] = LW'(ptx[0]) - LW'(ptx[2]);
    ax_d[1] = LW'(ptx[0]) - LW'(ptx[3]);
    ax_d[2] = LW'(ptx[1]) - LW'(ptx[3]);
    ax_d[3] = LW'(ptx[1]) - LW'(ptx[2]);
    ay_d[0] = LW'(pty[0]) - LW'(pty[2]);
    ay_d[1] = LW'(pty[0]) - LW'(pty[3]);
    ay_d[2] = LW'(pty[1]) - LW'(pty[3]);
    ay_d[3] = LW'(pty[1]) - LW'(pty[2]);
    axis_d = (ax_d[0] > lim && ax_d[1] > lim && ax_d[2] > lim && ax_d[3] > lim) ||
             (ax_d[0] < nlim && ax_d[1] < nlim && ax_d[2] < nlim && ax_d[3] < nlim) ||
             (ay_d[0] > lim && ay_d[1] > lim && ay_d[2] > lim && ay_d[3] > lim) ||
             (ay_d[0] < nlim && ay_d[1] < nlim && ay_d[2] < nlim && ay_d[3] < nlim);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      axis1_q  <= axis_d;
      degen1_q <= (ptx[0] == ptx[1] && pty[0] == pty[1]) ||
                  (ptx[2] == ptx[3] && pty[2] == pty[3]);
      b1_q     <= buf_q;
    end
  end

  // Point tests: segment second vs points 0,1; segment first vs points 2,3.
  for (genvar k = 0; k < 4; k++) begin : g_pt
    localparam int SI = (k < 2) ? 2 : 0;
    localparam int EI = SI + 1;
    logic signed [LW-1:0] psx, pex, psy, pey;
    logic                 rej_d;

    always_comb begin
      psx   = LW'(ptx[k]) - LW'(ptx[SI]);
      pex   = LW'(ptx[k]) - LW'(ptx[EI]);
      psy   = LW'(pty[k]) - LW'(pty[SI]);
      pey   = LW'(pty[k]) - LW'(pty[EI]);
      rej_d = (psx > lim && pex > lim) || (psx < nlim && pex < nlim) ||
              (psy > lim && pey > lim) || (psy < nlim && pey < nlim);
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        wx1_q[k]  <= DW'(ptx[SI]) - DW'(ptx[k]);
        wy1_q[k]  <= DW'(pty[SI]) - DW'(pty[k]);
        ux1_q[k]  <= DW'(ptx[EI]) - DW'(ptx[k]);
        uy1_q[k]  <= DW'(pty[EI]) - DW'(pty[k]);
        vx1_q[k]  <= DW'(ptx[EI]) - DW'(ptx[SI]);
        vy1_q[k]  <= DW'(pty[EI]) - DW'(pty[SI]);
        rej1_q[k] <= rej_d;
      end
    end
  end

  // Orientation differences for the crossing test.
  for (genvar j = 0; j < 4; j++) begin : g_or1
    localparam int AI = (j < 2) ? 0 : 2;
    localparam int BI = AI + 1;
    localparam int CI = (j < 2) ? j + 2 : j - 2;
    always_ff @(posedge clk_i) begin
      if (en) begin
        obx1_q[j] <= DW'(ptx[BI]) - DW'(ptx[AI]);
        oby1_q[j] <= DW'(pty[BI]) - DW'(pty[AI]);
        ocx1_q[j] <= DW'(ptx[CI]) - DW'(ptx[AI]);
        ocy1_q[j] <= DW'(pty[CI]) - DW'(pty[AI]);
      end
    end
  end

  // ---------------- Stage 2: products ------------------------------------
  logic signed [PW-1:0]  wxx2_q [4], wyy2_q [4], uxx2_q [4], uyy2_q [4];
  logic signed [PW-1:0]  vxx2_q [4], vyy2_q [4], dtx2_q [4], dty2_q [4];
  logic signed [PW-1:0]  cr12_q [4], cr22_q [4];
  logic signed [PW-1:0]  op12_q [4], op22_q [4];
  logic                  rej2_q [4];
  logic                  axis2_q, degen2_q;
  logic signed [DDW-1:0] dd2_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      axis2_q  <= axis1_q;
      degen2_q <= degen1_q;
      dd2_q    <= DDW'(b1_q) * DDW'(b1_q);
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_s2
    always_ff @(posedge clk_i) begin
      if (en) begin
        wxx2_q[k] <= wx1_q[k] * wx1_q[k];
        wyy2_q[k] <= wy1_q[k] * wy1_q[k];
        uxx2_q[k] <= ux1_q[k] * ux1_q[k];
        uyy2_q[k] <= uy1_q[k] * uy1_q[k];
        vxx2_q[k] <= vx1_q[k] * vx1_q[k];
        vyy2_q[k] <= vy1_q[k] * vy1_q[k];
        dtx2_q[k] <= wx1_q[k] * vx1_q[k];
        dty2_q[k] <= wy1_q[k] * vy1_q[k];
        cr12_q[k] <= vx1_q[k] * wy1_q[k];
        cr22_q[k] <= vy1_q[k] * wx1_q[k];
        rej2_q[k] <= rej1_q[k];
        op12_q[k] <= obx1_q[k] * ocy1_q[k];
        op22_q[k] <= oby1_q[k] * ocx1_q[k];
      end
    end
  end

  // ---------------- Stage 3: sums ----------------------------------------
  logic signed [SW-1:0]  c3_q [4], ce3_q [4], a3_q [4], dot3_q [4], cr3_q [4];
  logic                  opos3_q [4], oneg3_q [4];
  logic                  rej3_q [4];
  logic                  axis3_q, degen3_q;
  logic signed [DDW-1:0] dd3_q;
  logic signed [SW-1:0]  ov [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      axis3_q  <= axis2_q;
      degen3_q <= degen2_q;
      dd3_q    <= dd2_q;
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_s3
    assign ov[k] = SW'(op12_q[k]) - SW'(op22_q[k]);
    always_ff @(posedge clk_i) begin
      if (en) begin
        c3_q[k]    <= SW'(wxx2_q[k]) + SW'(wyy2_q[k]);
        ce3_q[k]   <= SW'(uxx2_q[k]) + SW'(uyy2_q[k]);
        a3_q[k]    <= SW'(vxx2_q[k]) + SW'(vyy2_q[k]);
        dot3_q[k]  <= SW'(dtx2_q[k]) + SW'(dty2_q[k]);
        cr3_q[k]   <= SW'(cr12_q[k]) - SW'(cr22_q[k]);
        rej3_q[k]  <= rej2_q[k];
        opos3_q[k] <= ov[k] > 0;
        oneg3_q[k] <= ov[k] < 0;
      end
    end
  end

  // ---------------- Stage 4: squared distance terms and flags ------------
  logic signed [2*SW-1:0]    crsq4_q [4];
  logic signed [SW+DDW-1:0]  ad4_q [4];
  logic                      near4_q [4], ok4_q [4], rej4_q [4];
  logic                      axis4_q, degen4_q, cross4_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      axis4_q  <= axis3_q;
      degen4_q <= degen3_q;
      cross4_q <= ((opos3_q[0] && oneg3_q[1]) || (oneg3_q[0] && opos3_q[1])) &&
                  ((opos3_q[2] && oneg3_q[3]) || (oneg3_q[2] && opos3_q[3]));
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_s4
    always_ff @(posedge clk_i) begin
      if (en) begin
        crsq4_q[k] <= cr3_q[k] * cr3_q[k];
        ad4_q[k]   <= a3_q[k] * dd3_q;
        near4_q[k] <= (c3_q[k] < dd3_q) || (ce3_q[k] < dd3_q);
        ok4_q[k]   <= (a3_q[k] != 0) && (dot3_q[k] <= 0) && (dot3_q[k] >= -a3_q[k]);
        rej4_q[k]  <= rej3_q[k];
      end
    end
  end

  // ---------------- Stage 5: decision and result register ----------------
  logic [3:0] hit;
  logic       close_d;
  how_e       how_d, how_q;
  logic       close_q;

  for (genvar k = 0; k < 4; k++) begin : g_hit
    assign hit[k] = !rej4_q[k] &&
                    (near4_q[k] || (ok4_q[k] && (crsq4_q[k] <= ad4_q[k])));
  end

  always_comb begin
    close_d = 1'b0;
    how_d   = HOW_NONE;
    if (axis4_q) begin
      how_d = HOW_AXIS;
    end else if (|hit) begin
      close_d = 1'b1;
      how_d   = HOW_POINT;
    end else if (degen4_q) begin
      how_d = HOW_DEGEN;
    end else if (cross4_q) begin
      close_d = 1'b1;
      how_d   = HOW_CROSS;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      close_q <= close_d;
      how_q   <= how_d;
    end
  end

  assign res_o.valid      = v5_q;
  assign res_o.close      = close_q;
  assign res_o.decided_by = how_q;

endmodule

>>> src/spp_checker.sv
// ----------------------------------------------------------------------------
// spp_checker
// Port-level checks of the segment pair proximity test.
// ----------------------------------------------------------------------------
module spp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic       close_i,
  input logic [2:0] decided_by_i
);
  import spp_pkg::*;

  // A stalled result holds its value.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(close_i) && $stable(decided_by_i))
    else $error("result changed while stalled");

  // The flag agrees with the deciding rule.
  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> close_i == (decided_by_i == HOW_POINT || decided_by_i == HOW_CROSS))
    else $error("close flag disagrees with decided_by");

  // Only defined rule codes appear.
  a_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> decided_by_i <= HOW_NONE)
    else $error("undefined decided_by code");

  // Input is held off only by a stalled result.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i && !out_ready_i)
    else $error("input stalled without an output stall");

endmodule

bind segment_pair_proximity_test spp_checker u_spp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_i   (seg_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .close_i      (res_o.close),
  .decided_by_i (res_o.decided_by)
);
